// File: rtl/psg_pkg.sv
// Shared constants, types and lookup functions for the three-voice sound generator.
// Used by every module under rtl; depends on nothing else.
package psg_pkg;

  localparam int NUM_CH      = 3;
  localparam int TONE_W      = 12;
  localparam int NOISE_CNT_W = 5;
  localparam int LFSR_W      = 17;
  localparam int ENV_CNT_W   = 16;
  localparam int ENV_POS_W   = 7;
  localparam int LEVEL_W     = 5;
  localparam int FIXED_W     = 4;
  localparam int SHAPE_W     = 4;
  localparam int MIX_W       = 2 * NUM_CH;
  localparam int VOL_W       = LEVEL_W * NUM_CH;
  localparam int DAC_W       = LEVEL_W * NUM_CH;
  localparam int CFG_DATA_W  = TONE_W * NUM_CH;
  localparam int CFG_IDX_W   = 3;

  localparam logic [LFSR_W-1:0]    LFSR_TAPS    = 17'h12000;
  localparam logic [LFSR_W-1:0]    LFSR_SEED    = 17'h00001;
  localparam logic [ENV_POS_W-1:0] ENV_POS_LAST = 7'd95;
  localparam logic [ENV_POS_W-1:0] ENV_POS_LOOP = 7'd32;
  localparam logic [LEVEL_W-1:0]   LEVEL_MAX    = 5'd31;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TONE_PERIODS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_PERIOD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIXER_DISABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_VOLUMES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_SHAPE  = 3'd5;

  // Kinds of one 32-step envelope block.
  localparam logic [1:0] KIND_FALL = 2'd0;
  localparam logic [1:0] KIND_RISE = 2'd1;
  localparam logic [1:0] KIND_LOW  = 2'd2;
  localparam logic [1:0] KIND_HIGH = 2'd3;

  // Per shape: {third block, second block, first block}.
  localparam logic [5:0] SHAPE_TABLE [16] = '{
    {KIND_LOW,  KIND_LOW,  KIND_FALL}, {KIND_LOW,  KIND_LOW,  KIND_FALL},
    {KIND_LOW,  KIND_LOW,  KIND_FALL}, {KIND_LOW,  KIND_LOW,  KIND_FALL},
    {KIND_LOW,  KIND_LOW,  KIND_RISE}, {KIND_LOW,  KIND_LOW,  KIND_RISE},
    {KIND_LOW,  KIND_LOW,  KIND_RISE}, {KIND_LOW,  KIND_LOW,  KIND_RISE},
    {KIND_FALL, KIND_FALL, KIND_FALL}, {KIND_LOW,  KIND_LOW,  KIND_FALL},
    {KIND_FALL, KIND_RISE, KIND_FALL}, {KIND_HIGH, KIND_HIGH, KIND_FALL},
    {KIND_RISE, KIND_RISE, KIND_RISE}, {KIND_HIGH, KIND_HIGH, KIND_RISE},
    {KIND_RISE, KIND_FALL, KIND_RISE}, {KIND_LOW,  KIND_LOW,  KIND_RISE}
  };

  localparam logic [LEVEL_W-1:0] FIXED_TO_FIVE [16] = '{
    5'd0,  5'd1,  5'd5,  5'd7,  5'd9,  5'd11, 5'd13, 5'd15,
    5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd29, 5'd31
  };

  // Levels that the mixer needs from the generators for one tick.
  typedef struct packed {
    logic [NUM_CH-1:0]  tone_level;
    logic               noise_bit;
    logic [LEVEL_W-1:0] env_level;
  } voice_status_t;

  function automatic logic [LEVEL_W-1:0] env_level_of(
    input logic [SHAPE_W-1:0]   shape,
    input logic [ENV_POS_W-1:0] pos
  );
    logic [5:0]         blocks;
    logic [1:0]         kind;
    logic [LEVEL_W-1:0] step;
    logic [LEVEL_W-1:0] level;
    blocks = SHAPE_TABLE[shape];
    step   = pos[LEVEL_W-1:0];
    unique case (pos[ENV_POS_W-1:LEVEL_W])
      2'd0:    kind = blocks[1:0];
      2'd1:    kind = blocks[3:2];
      default: kind = blocks[5:4];
    endcase
    unique case (kind)
      KIND_FALL: level = LEVEL_MAX - step;
      KIND_RISE: level = step;
      KIND_HIGH: level = LEVEL_MAX;
      default:   level = '0;
    endcase
    return level;
  endfunction

endpackage

// File: rtl/psg_tone_noise_envelope_engine_core.sv
// Top level of the three-voice sound generator: configuration registers,
// stream handshake, generators, mixer and the output register.
// Depends on psg_pkg, psg_tone_noise, psg_envelope and psg_mixer.
// Each accepted tick has its result registered into m_axis_tdata in the cycle after the tick.
// Throughput: one tick per cycle; s_axis_tready falls only while a result is held back.
// Reset (rst, synchronous): clears all but dac_index and noise_level; seeds the LFSR to 1.
module psg_tone_noise_envelope_engine_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [0] restart_envelope, [7:1] zero
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // [14:0] dac_index, [15] noise_level
  input  logic                            cfg_wen,
  input  logic [psg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import psg_pkg::*;

  logic [CFG_DATA_W-1:0]  tone_periods;
  logic [NOISE_CNT_W-1:0] noise_period;
  logic [MIX_W-1:0]       mixer_disable;
  logic [VOL_W-1:0]       channel_volumes;
  logic [ENV_CNT_W-1:0]   envelope_period;
  logic [SHAPE_W-1:0]     envelope_shape;

  logic                   tick;
  voice_status_t          status;
  logic [DAC_W-1:0]       dac_index_next;
  logic [DAC_W-1:0]       dac_index;
  logic                   noise_level;
  logic                   out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_periods    <= '0;
      noise_period    <= '0;
      mixer_disable   <= '0;
      channel_volumes <= '0;
      envelope_period <= '0;
      envelope_shape  <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_TONE_PERIODS:    tone_periods    <= cfg_wdata;
        REG_NOISE_PERIOD:    noise_period    <= cfg_wdata[NOISE_CNT_W-1:0];
        REG_MIXER_DISABLE:   mixer_disable   <= cfg_wdata[MIX_W-1:0];
        REG_CHANNEL_VOLUMES: channel_volumes <= cfg_wdata[VOL_W-1:0];
        REG_ENVELOPE_PERIOD: envelope_period <= cfg_wdata[ENV_CNT_W-1:0];
        REG_ENVELOPE_SHAPE:  envelope_shape  <= cfg_wdata[SHAPE_W-1:0];
        default: ;
      endcase
    end
  end

  // The output register frees up in the same cycle its transaction completes.
  assign s_axis_tready = ~out_valid | m_axis_tready;
  assign tick          = s_axis_tvalid & s_axis_tready;

  psg_tone_noise u_tone_noise (
    .clk             (clk),
    .rst             (rst),
    .tick            (tick),
    .tone_periods    (tone_periods),
    .noise_period    (noise_period),
    .tone_level_next (status.tone_level),
    .noise_bit_next  (status.noise_bit)
  );

  psg_envelope u_envelope (
    .clk             (clk),
    .rst             (rst),
    .tick            (tick),
    .restart         (s_axis_tdata[0]),
    .envelope_period (envelope_period),
    .envelope_shape  (envelope_shape),
    .env_level       (status.env_level)
  );

  psg_mixer u_mixer (
    .status          (status),
    .mixer_disable   (mixer_disable),
    .channel_volumes (channel_volumes),
    .dac_index       (dac_index_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      dac_index   <= dac_index_next;
      noise_level <= status.noise_bit;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {noise_level, dac_index};

`ifndef SYNTH
  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    tick |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !tick)
    else $error("tick accepted while a result is held back");

  a_result_one_per_tick: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !tick |=> !m_axis_tvalid)
    else $error("result repeated without a new tick");
`endif

endmodule

// File: rtl/psg_tone_noise.sv
// Three square-wave tone counters and the half-rate noise LFSR.
// Depends on psg_pkg.
module psg_tone_noise (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           tick,
  input  logic [psg_pkg::CFG_DATA_W-1:0]                 tone_periods,
  input  logic [psg_pkg::NOISE_CNT_W-1:0]                noise_period,
  output logic [psg_pkg::NUM_CH-1:0]                     tone_level_next,
  output logic                                           noise_bit_next
);
  import psg_pkg::*;

  logic [TONE_W-1:0]      tone_count      [NUM_CH];
  logic [TONE_W-1:0]      tone_count_next [NUM_CH];
  logic [TONE_W:0]        tone_sum        [NUM_CH];
  logic [NUM_CH-1:0]      tone_level;
  logic                   half_rate;
  logic [NOISE_CNT_W-1:0] noise_count;
  logic [NOISE_CNT_W-1:0] noise_count_next;
  logic [NOISE_CNT_W:0]   noise_sum;
  logic [NOISE_CNT_W-1:0] noise_per;
  logic                   noise_bit;
  logic [LFSR_W-1:0]      noise_shift;
  logic [LFSR_W-1:0]      noise_shift_next;

  // A count that reaches its period (or one past a lowered period) wraps.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      tone_sum[ch] = {1'b0, tone_count[ch]} + {{TONE_W{1'b0}}, 1'b1};
      if (tone_sum[ch] >= {1'b0, tone_periods[TONE_W*ch +: TONE_W]}) begin
        tone_count_next[ch] = '0;
        tone_level_next[ch] = ~tone_level[ch];
      end else begin
        tone_count_next[ch] = tone_sum[ch][TONE_W-1:0];
        tone_level_next[ch] = tone_level[ch];
      end
    end
  end

  // The noise counter advances on every second tick only.
  always_comb begin
    noise_per        = (noise_period == '0) ? NOISE_CNT_W'(1) : noise_period;
    noise_sum        = {1'b0, noise_count} + {{NOISE_CNT_W{1'b0}}, 1'b1};
    noise_count_next = noise_count;
    noise_shift_next = noise_shift;
    noise_bit_next   = noise_bit;
    if (half_rate) begin
      if (noise_sum >= {1'b0, noise_per}) begin
        noise_count_next = '0;
        noise_bit_next   = noise_shift[0];
        if (noise_shift[0]) begin
          noise_shift_next = (noise_shift >> 1) ^ LFSR_TAPS;
        end else begin
          noise_shift_next = noise_shift >> 1;
        end
      end else begin
        noise_count_next = noise_sum[NOISE_CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        tone_count[ch] <= '0;
      end
      tone_level  <= '0;
      half_rate   <= 1'b0;
      noise_count <= '0;
      noise_bit   <= 1'b0;
      noise_shift <= LFSR_SEED;
    end else if (tick) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        tone_count[ch] <= tone_count_next[ch];
      end
      tone_level  <= tone_level_next;
      half_rate   <= ~half_rate;
      noise_count <= noise_count_next;
      noise_bit   <= noise_bit_next;
      noise_shift <= noise_shift_next;
    end
  end

`ifndef SYNTH
  // The LFSR must never fall into the all-zero lockup state.
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (rst)
    noise_shift != '0)
    else $error("noise LFSR reached the all-zero state");
`endif

endmodule

// File: rtl/psg_envelope.sv
// Envelope step counter, position sequencer and shape lookup.
// Depends on psg_pkg.
module psg_envelope (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tick,
  input  logic                           restart,
  input  logic [psg_pkg::ENV_CNT_W-1:0]  envelope_period,
  input  logic [psg_pkg::SHAPE_W-1:0]    envelope_shape,
  output logic [psg_pkg::LEVEL_W-1:0]    env_level
);
  import psg_pkg::*;

  logic [ENV_CNT_W-1:0] count;
  logic [ENV_CNT_W-1:0] count_base;
  logic [ENV_CNT_W-1:0] count_next;
  logic [ENV_CNT_W:0]   count_sum;
  logic [ENV_CNT_W-1:0] period;
  logic [ENV_POS_W-1:0] position;
  logic [ENV_POS_W-1:0] position_base;
  logic [ENV_POS_W-1:0] position_next;

  // A restart clears count and position before the tick is applied.
  always_comb begin
    count_base    = restart ? '0 : count;
    position_base = restart ? '0 : position;
    period        = (envelope_period == '0) ? ENV_CNT_W'(1) : envelope_period;
    count_sum     = {1'b0, count_base} + {{ENV_CNT_W{1'b0}}, 1'b1};
    if (count_sum >= {1'b0, period}) begin
      count_next = '0;
      // After the last position the sequence repeats its last two blocks.
      if (position_base == ENV_POS_LAST) begin
        position_next = ENV_POS_LOOP;
      end else begin
        position_next = position_base + ENV_POS_W'(1);
      end
    end else begin
      count_next    = count_sum[ENV_CNT_W-1:0];
      position_next = position_base;
    end
    env_level = env_level_of(envelope_shape, position_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      position <= '0;
    end else if (tick) begin
      count    <= count_next;
      position <= position_next;
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position <= ENV_POS_LAST)
    else $error("envelope position beyond its last step");

  a_restart_pos: assert property (@(posedge clk) disable iff (rst)
    tick && restart |=> position <= ENV_POS_W'(1))
    else $error("envelope position not cleared by restart");
`endif

endmodule

// File: rtl/psg_mixer.sv
// Per-channel tone/noise gate and fixed or envelope volume selection.
// Depends on psg_pkg; purely combinational.
module psg_mixer (
  input  psg_pkg::voice_status_t         status,
  input  logic [psg_pkg::MIX_W-1:0]      mixer_disable,
  input  logic [psg_pkg::VOL_W-1:0]      channel_volumes,
  output logic [psg_pkg::DAC_W-1:0]      dac_index
);
  import psg_pkg::*;

  logic [LEVEL_W-1:0] vol  [NUM_CH];
  logic [LEVEL_W-1:0] amp  [NUM_CH];
  logic [NUM_CH-1:0]  gate;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      vol[ch]  = channel_volumes[LEVEL_W*ch +: LEVEL_W];
      amp[ch]  = vol[ch][LEVEL_W-1] ? status.env_level
                                    : FIXED_TO_FIVE[vol[ch][FIXED_W-1:0]];
      gate[ch] = (status.tone_level[ch] | mixer_disable[ch]) &
                 (status.noise_bit | mixer_disable[ch + NUM_CH]);
      dac_index[LEVEL_W*ch +: LEVEL_W] = gate[ch] ? amp[ch] : '0;
    end
  end

endmodule

// File: tb/psg_engine_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the three-voice sound generator: it snoops the configuration port and both
// stream channels, keeps its own tick-level copy of the generators and checks every result.
// Depends on psg_pkg for widths, register indexes and envelope block kinds.
module psg_engine_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [0] restart_envelope, [7:1] zero
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [15:0]                     m_axis_tdata,  // [14:0] dac_index, [15] noise_level
  input  logic                            cfg_wen,
  input  logic [psg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              mismatches,
  output int                              ticks_pending,
  output int                              ticks_checked,
  output int                              env_restarts
);
  import psg_pkg::*;

  typedef struct packed {
    logic               noise_level;
    logic [DAC_W-1:0]   dac_index;
  } tick_result_t;

  localparam logic [LFSR_W-1:0] NOISE_TAPS = 17'h12000;

  // Block kinds per shape, first block first.
  localparam logic [1:0] ENV_BLOCKS [16][3] = '{
    '{KIND_FALL, KIND_LOW,  KIND_LOW},  '{KIND_FALL, KIND_LOW,  KIND_LOW},
    '{KIND_FALL, KIND_LOW,  KIND_LOW},  '{KIND_FALL, KIND_LOW,  KIND_LOW},
    '{KIND_RISE, KIND_LOW,  KIND_LOW},  '{KIND_RISE, KIND_LOW,  KIND_LOW},
    '{KIND_RISE, KIND_LOW,  KIND_LOW},  '{KIND_RISE, KIND_LOW,  KIND_LOW},
    '{KIND_FALL, KIND_FALL, KIND_FALL}, '{KIND_FALL, KIND_LOW,  KIND_LOW},
    '{KIND_FALL, KIND_RISE, KIND_FALL}, '{KIND_FALL, KIND_HIGH, KIND_HIGH},
    '{KIND_RISE, KIND_RISE, KIND_RISE}, '{KIND_RISE, KIND_HIGH, KIND_HIGH},
    '{KIND_RISE, KIND_FALL, KIND_RISE}, '{KIND_RISE, KIND_LOW,  KIND_LOW}
  };

  // Register copies.
  logic [CFG_DATA_W-1:0] tone_periods;
  logic [NOISE_CNT_W-1:0] noise_period;
  logic [MIX_W-1:0]      mixer_off;
  logic [VOL_W-1:0]      volumes;
  logic [ENV_CNT_W-1:0]  env_period;
  logic [SHAPE_W-1:0]    env_shape;

  // Generator state.
  logic [TONE_W-1:0]      tone_cnt [NUM_CH];
  logic [NUM_CH-1:0]      tone_lvl;
  logic                   half_tick;
  logic [NOISE_CNT_W-1:0] noise_cnt;
  logic                   noise_bit;
  logic [LFSR_W-1:0]      lfsr;
  logic [ENV_CNT_W-1:0]   env_cnt;
  logic [ENV_POS_W-1:0]   env_pos;

  tick_result_t expected_ticks [$];
  int fail_count = 0;
  int checked    = 0;
  int restarts   = 0;

  assign mismatches    = fail_count;
  assign ticks_checked = checked;
  assign env_restarts  = restarts;

  function automatic logic [LEVEL_W-1:0] fixed_level(input logic [FIXED_W-1:0] f);
    // 0 and 1 map to themselves, the rest to 2f+1.
    return (f < 2) ? {1'b0, f} : {f, 1'b1};
  endfunction

  function automatic logic [LEVEL_W-1:0] envelope_out(input logic [SHAPE_W-1:0] shape,
                                                      input logic [ENV_POS_W-1:0] pos);
    logic [1:0] kind;
    logic [4:0] i;
    kind = ENV_BLOCKS[shape][2'((pos >> 5) % 3)];
    i    = pos[4:0];
    case (kind)
      KIND_FALL: return 5'd31 - i;
      KIND_RISE: return i;
      KIND_HIGH: return 5'd31;
      default:   return 5'd0;
    endcase
  endfunction

  task automatic clear_generators();
    tone_periods = '0;
    noise_period = '0;
    mixer_off    = '0;
    volumes      = '0;
    env_period   = '0;
    env_shape    = '0;
    for (int ch = 0; ch < NUM_CH; ch++) tone_cnt[ch] = '0;
    tone_lvl  = '0;
    half_tick = 1'b0;
    noise_cnt = '0;
    noise_bit = 1'b0;
    lfsr      = 17'd1;
    env_cnt   = '0;
    env_pos   = '0;
  endtask

  task automatic run_tick(input logic restart, output tick_result_t res);
    logic [TONE_W:0]      tone_nxt;
    logic [TONE_W-1:0]    per;
    logic [NOISE_CNT_W:0] noise_nxt;
    logic [NOISE_CNT_W:0] nper;
    logic [ENV_CNT_W:0]   env_nxt;
    logic [ENV_CNT_W:0]   eper;
    logic [LEVEL_W-1:0]   env;
    logic [LEVEL_W-1:0]   amp;
    logic [LEVEL_W-1:0]   vreg;
    res = '0;
    if (restart) begin
      env_cnt = '0;
      env_pos = '0;
    end

    // The noise counter only moves on every second tick.
    half_tick = ~half_tick;
    if (!half_tick) begin
      nper      = (noise_period == 0) ? 6'd1 : {1'b0, noise_period};
      noise_nxt = {1'b0, noise_cnt} + 6'd1;
      if (noise_nxt >= nper) begin
        noise_cnt = '0;
        noise_bit = lfsr[0];
        lfsr      = lfsr[0] ? ((lfsr >> 1) ^ NOISE_TAPS) : (lfsr >> 1);
      end else begin
        noise_cnt = noise_nxt[NOISE_CNT_W-1:0];
      end
    end

    for (int ch = 0; ch < NUM_CH; ch++) begin
      per      = tone_periods[TONE_W*ch +: TONE_W];
      tone_nxt = {1'b0, tone_cnt[ch]} + 13'd1;
      if (tone_nxt >= {1'b0, per}) begin
        tone_cnt[ch] = '0;
        tone_lvl[ch] = ~tone_lvl[ch];
      end else begin
        tone_cnt[ch] = tone_nxt[TONE_W-1:0];
      end
    end

    eper    = (env_period == 0) ? 17'd1 : {1'b0, env_period};
    env_nxt = {1'b0, env_cnt} + 17'd1;
    if (env_nxt >= eper) begin
      env_cnt = '0;
      env_pos = env_pos + 7'd1;
      if (env_pos >= 7'd96) env_pos = env_pos - 7'd64;
    end else begin
      env_cnt = env_nxt[ENV_CNT_W-1:0];
    end

    env = envelope_out(env_shape, env_pos);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      vreg = volumes[LEVEL_W*ch +: LEVEL_W];
      amp  = vreg[4] ? env : fixed_level(vreg[3:0]);
      if ((tone_lvl[ch] | mixer_off[ch]) && (noise_bit | mixer_off[ch+NUM_CH]))
        res.dac_index[LEVEL_W*ch +: LEVEL_W] = amp;
    end
    res.noise_level = noise_bit;
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    tick_result_t got;
    if (rst) begin
      clear_generators();
      expected_ticks.delete();
    end else begin
      // A result leaves in the cycle after its tick at the earliest, so the output side
      // is settled before this edge's tick is added.
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_ticks.size() == 0) begin
          $error("result transaction with no tick outstanding: %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_ticks.pop_front();
          checked++;
          if (got.dac_index !== want.dac_index) begin
            $error("dac_index mismatch: expected %h, actual %h", want.dac_index, got.dac_index);
            fail_count++;
          end
          if (got.noise_level !== want.noise_level) begin
            $error("noise_level mismatch: expected %b, actual %b",
                   want.noise_level, got.noise_level);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tdata[0]) restarts++;
        run_tick(s_axis_tdata[0], want);
        expected_ticks.push_back(want);
      end
      if (cfg_wen) begin
        case (cfg_index)
          REG_TONE_PERIODS:    tone_periods = cfg_wdata;
          REG_NOISE_PERIOD:    noise_period = cfg_wdata[NOISE_CNT_W-1:0];
          REG_MIXER_DISABLE:   mixer_off    = cfg_wdata[MIX_W-1:0];
          REG_CHANNEL_VOLUMES: volumes      = cfg_wdata[VOL_W-1:0];
          REG_ENVELOPE_PERIOD: env_period   = cfg_wdata[ENV_CNT_W-1:0];
          REG_ENVELOPE_SHAPE:  env_shape    = cfg_wdata[SHAPE_W-1:0];
          default: ;
        endcase
      end
    end
    ticks_pending <= expected_ticks.size();
  end

endmodule

// File: tb/tb_psg_tone_noise_envelope_engine_core.sv
`timescale 1ns / 1ps
// Top of the sound generator testbench: clock, reset, register programming, tick stimulus
// and random back-pressure. Checking lives in psg_engine_checker.
// Depends on psg_pkg, the block under test and psg_engine_checker.
module tb_psg_tone_noise_envelope_engine_core;
  import psg_pkg::*;

  localparam int RANDOM_TICKS = 1400;
  localparam int STALL_LIMIT  = 4000;

  // Indexes that hold no register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct {
    logic [CFG_DATA_W-1:0]  tones;
    logic [NOISE_CNT_W-1:0] noise;
    logic [MIX_W-1:0]       mix;
    logic [VOL_W-1:0]       vols;
    logic [ENV_CNT_W-1:0]   env_per;
    logic [SHAPE_W-1:0]     shape;
  } psg_setting_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int ticks_pending;
  int ticks_checked;
  int env_restarts;

  logic sink_free;
  int   sink_left = 0;
  int   quiet     = 0;
  bit   gaps_on;
  int   settings_applied = 0;

  psg_tone_noise_envelope_engine_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  psg_engine_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .ticks_pending (ticks_pending),
    .ticks_checked (ticks_checked),
    .env_restarts  (env_restarts)
  );

  always #10 clk = ~clk;

  // Result sink: runs of ready broken by stalls, mostly short and now and then long.
  always @(posedge clk) begin
    int r;
    if (sink_free) begin
      m_axis_tready <= 1'b1;
    end else if (sink_left > 0) begin
      sink_left--;
    end else if (m_axis_tready) begin
      r = $urandom_range(0, 99);
      m_axis_tready <= 1'b0;
      sink_left = (r < 80) ? $urandom_range(0, 2) :
                  (r < 95) ? $urandom_range(3, 10) : $urandom_range(20, 60);
    end else begin
      m_axis_tready <= 1'b1;
      sink_left = $urandom_range(0, 30);
    end
  end

  // Ends the run if no transaction moves on either stream for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("tb_psg_tone_noise_envelope_engine_core failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int tick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Keeps the register value in the low bits and fills the unused upper bits with noise.
  function automatic logic [CFG_DATA_W-1:0] junk_above(input logic [CFG_DATA_W-1:0] v,
                                                        input int w);
    logic [CFG_DATA_W-1:0] keep;
    logic [CFG_DATA_W-1:0] r;
    keep = (36'd1 << w) - 36'd1;
    r    = CFG_DATA_W'({$urandom, $urandom});
    return (r & ~keep) | (v & keep);
  endfunction

  function automatic logic [TONE_W-1:0] pick_tone_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return TONE_W'($urandom_range(0, 8));
    if (r < 80) return TONE_W'($urandom_range(9, 64));
    if (r < 95) return TONE_W'($urandom_range(0, 4095));
    return (r < 98) ? 12'd0 : 12'hFFF;
  endfunction

  function automatic psg_setting_t pick_setting();
    psg_setting_t s;
    int r;
    for (int ch = 0; ch < NUM_CH; ch++) s.tones[TONE_W*ch +: TONE_W] = pick_tone_period();
    s.noise = NOISE_CNT_W'($urandom_range(0, 31));
    s.mix   = MIX_W'($urandom_range(0, 63));
    s.vols  = VOL_W'($urandom_range(0, 32767));
    s.shape = SHAPE_W'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    // Short envelope periods keep the position moving through all three blocks.
    s.env_per = ENV_CNT_W'((r < 70) ? $urandom_range(0, 4) :
                           (r < 90) ? $urandom_range(5, 40) :
                           (r < 95) ? 65535 : $urandom_range(0, 65535));
    return s;
  endfunction

  task automatic apply_setting(input psg_setting_t s);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_TONE_PERIODS;
    cfg_wdata <= s.tones;
    @(posedge clk);
    cfg_index <= REG_NOISE_PERIOD;
    cfg_wdata <= junk_above(CFG_DATA_W'(s.noise), NOISE_CNT_W);
    @(posedge clk);
    cfg_index <= REG_MIXER_DISABLE;
    cfg_wdata <= junk_above(CFG_DATA_W'(s.mix), MIX_W);
    @(posedge clk);
    cfg_index <= REG_CHANNEL_VOLUMES;
    cfg_wdata <= junk_above(CFG_DATA_W'(s.vols), VOL_W);
    @(posedge clk);
    cfg_index <= REG_ENVELOPE_PERIOD;
    cfg_wdata <= junk_above(CFG_DATA_W'(s.env_per), ENV_CNT_W);
    @(posedge clk);
    cfg_index <= REG_ENVELOPE_SHAPE;
    cfg_wdata <= junk_above(CFG_DATA_W'(s.shape), SHAPE_W);
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    settings_applied++;
  endtask

  task automatic write_spare();
    cfg_wen   <= 1'b1;
    cfg_index <= REG_SPARE_6;
    cfg_wdata <= CFG_DATA_W'({$urandom, $urandom});
    @(posedge clk);
    cfg_index <= REG_SPARE_7;
    cfg_wdata <= CFG_DATA_W'({$urandom, $urandom});
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // Returns at the edge at which the tick transaction completes; tvalid stays high.
  task automatic send_tick(input logic restart);
    int gap;
    gap = tick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, restart};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stops sending and waits until every tick has its result back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (ticks_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    psg_setting_t s;
    int phase_len;
    int restart_pct;
    int sent;
    int phase;
    int r;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_wen       = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    sink_free     = 1'b0;
    gaps_on       = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Registers still at reset: all tone periods zero, so every square toggles each tick.
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);

    // Every register at its maximum.
    wait_drained();
    s = '{tones: 36'hFFFFFFFFF, noise: 5'h1F, mix: 6'h3F, vols: 15'h7FFF,
          env_per: 16'hFFFF, shape: 4'hF};
    apply_setting(s);
    gaps_on = 1'b1;
    for (int k = 0; k < 6; k++) send_tick(k[0]);

    // Tone periods drop below the running counts; channel volumes mix envelope, the
    // top fixed level and a mid fixed level, with the envelope stepping every tick.
    wait_drained();
    write_spare();
    s = '{tones: 36'h002_001_000, noise: 5'h00, mix: 6'h00, vols: 15'b00111_01111_10000,
          env_per: 16'h0000, shape: 4'hA};
    apply_setting(s);
    for (int k = 0; k < 8; k++) send_tick(k == 3);

    // Mixed gate overrides and the lowest fixed levels.
    wait_drained();
    s = '{tones: 36'h000_003_001, noise: 5'h01, mix: 6'b101010, vols: 15'b00001_00010_00000,
          env_per: 16'h0001, shape: 4'h0};
    apply_setting(s);
    for (int k = 0; k < 5; k++) send_tick(1'b0);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_TICKS) begin
      phase++;
      wait_drained();
      if ($urandom_range(0, 9) == 0) write_spare();
      r = $urandom_range(0, 9);
      if (r == 0)
        s = '{tones: 36'hFFFFFFFFF, noise: 5'h1F, mix: 6'h3F, vols: 15'h7FFF,
              env_per: 16'hFFFF, shape: 4'hF};
      else if (r == 1)
        s = '{tones: '0, noise: '0, mix: '0, vols: '0, env_per: '0, shape: '0};
      else
        s = pick_setting();
      apply_setting(s);
      gaps_on = ($urandom_range(0, 3) != 0);
      sink_free <= ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0:       restart_pct = 0;
        1:       restart_pct = 2;
        2:       restart_pct = 10;
        default: restart_pct = 50;
      endcase
      phase_len = $urandom_range(20, 150);
      for (int k = 0; k < phase_len; k++) begin
        send_tick($urandom_range(0, 99) < restart_pct);
        // Now and then hold off mid-phase until the output side is empty.
        if (k == phase_len / 2 && phase % 4 == 0) wait_drained();
      end
      sent += phase_len;
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Summary: %0d ticks checked under %0d register settings,", ticks_checked,
             settings_applied);
    $display("Summary: %0d ticks restarted the envelope.", env_restarts);
    if (mismatches == 0) begin
      $display("tb_psg_tone_noise_envelope_engine_core passed");
    end else begin
      $display("tb_psg_tone_noise_envelope_engine_core failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/psg_pkg.sv
rtl/psg_tone_noise.sv
rtl/psg_envelope.sv
rtl/psg_mixer.sv
rtl/psg_tone_noise_envelope_engine_core.sv
tb/psg_engine_checker.sv
tb/tb_psg_tone_noise_envelope_engine_core.sv
